@@ src/fpsr_pkg.sv @@
package fpsr_pkg;

	// radicand is the 16-bit word scaled by 128, 23 bits used, held in 24
	localparam int unsigned RAD_W = 24;
	localparam int unsigned IN_W = 16;
	localparam int unsigned ROOT_W = 12;
	localparam int unsigned SCALE_SHIFT = 7;
	localparam int unsigned TOP_BIT = 22;
	localparam int unsigned NUM_STEPS = 12;
	localparam int unsigned STEPS_PER_STAGE = 2;
	localparam int unsigned NUM_STAGES = NUM_STEPS / STEPS_PER_STAGE;

	// partial result that travels down the pipe
	typedef struct packed {
		logic             valid;
		logic [RAD_W-1:0] rem;
		logic [RAD_W-1:0] acc;
	} fpsr_work_t;

endpackage

@@ src/fixed_point_square_root_unit.sv @@
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------
// input     | in_valid / in_stall  | radicand_raw [15:0], raw 9.7 word
// output    | out_valid / out_stall| root_raw [11:0], floor sqrt(x*128)
//
// one transaction per cycle unless out_stall holds a waiting result;
// six stages of two restoring steps each; a result shows on out_valid
// once it is in the last stage register and is taken while out_stall is low
// arst_n clears the valid bit of every stage, payload registers keep junk
// out_stall with a waiting result freezes the whole pipe and raises in_stall
module fixed_point_square_root_unit
	import fpsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [IN_W-1:0]   radicand_raw,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ROOT_W-1:0] root_raw
);

	fpsr_work_t entry;
	fpsr_work_t stage_s1;
	fpsr_work_t stage_s2;
	fpsr_work_t stage_s3;
	fpsr_work_t stage_s4;
	fpsr_work_t stage_s5;
	fpsr_work_t stage_s6;
	logic       en;

	// the pipe moves unless a finished result is held by the consumer
	assign en       = !(stage_s6.valid && out_stall);
	assign in_stall = !en;

	// scale by 128: the raw word sits above seven zero bits
	assign entry.valid = in_valid;
	assign entry.rem   = {{(RAD_W - IN_W - SCALE_SHIFT){1'b0}}, radicand_raw,
		{SCALE_SHIFT{1'b0}}};
	assign entry.acc   = '0;

	fpsr_stage #(.STEP_BASE(0)) u_st1 (
		.clk(clk), .arst_n(arst_n), .en(en), .work_in(entry), .work_out(stage_s1)
	);
	fpsr_stage #(.STEP_BASE(2)) u_st2 (
		.clk(clk), .arst_n(arst_n), .en(en), .work_in(stage_s1), .work_out(stage_s2)
	);
	fpsr_stage #(.STEP_BASE(4)) u_st3 (
		.clk(clk), .arst_n(arst_n), .en(en), .work_in(stage_s2), .work_out(stage_s3)
	);
	fpsr_stage #(.STEP_BASE(6)) u_st4 (
		.clk(clk), .arst_n(arst_n), .en(en), .work_in(stage_s3), .work_out(stage_s4)
	);
	fpsr_stage #(.STEP_BASE(8)) u_st5 (
		.clk(clk), .arst_n(arst_n), .en(en), .work_in(stage_s4), .work_out(stage_s5)
	);
	fpsr_stage #(.STEP_BASE(10)) u_st6 (
		.clk(clk), .arst_n(arst_n), .en(en), .work_in(stage_s5), .work_out(stage_s6)
	);

	// after the last step the accumulator holds the root itself
	assign out_valid = stage_s6.valid;
	assign root_raw  = stage_s6.acc[ROOT_W-1:0];

	// remainder of the last stage is not needed
	logic unused_rem;
	assign unused_rem = ^{stage_s6.rem, stage_s6.acc[RAD_W-1:ROOT_W]};

endmodule

@@ src/fpsr_stage.sv @@
module fpsr_stage
	import fpsr_pkg::*;
#(
	parameter int unsigned STEP_BASE = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  fpsr_work_t work_in,
	output fpsr_work_t work_out
);

	fpsr_work_t       nxt;
	logic             valid_sn;
	logic [RAD_W-1:0] rem_sn;
	logic [RAD_W-1:0] acc_sn;

	// restoring steps of this stage, one root bit each
	always_comb begin
		logic [RAD_W-1:0] rem;
		logic [RAD_W-1:0] acc;
		logic [RAD_W-1:0] probe;
		logic [RAD_W:0]   trial;
		rem = work_in.rem;
		acc = work_in.acc;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			probe = RAD_W'(1) << (TOP_BIT - 2 * (STEP_BASE + i));
			trial = {1'b0, acc} + {1'b0, probe};
			if ({1'b0, rem} >= trial) begin
				rem = rem - trial[RAD_W-1:0];
				acc = (acc >> 1) + probe;
			end else begin
				acc = acc >> 1;
			end
		end
		nxt.valid = work_in.valid;
		nxt.rem   = rem;
		nxt.acc   = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sn <= nxt.rem;
			acc_sn <= nxt.acc;
		end
	end

	assign work_out = {valid_sn, rem_sn, acc_sn};

endmodule

@@ src/fpsr_checker.sv @@
module fpsr_checker
	import fpsr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [ROOT_W-1:0] root_raw
);

	localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(2896);

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(root_raw))
		else $error("result changed while stalled");

	// input is only held off by a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall without output stall");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> root_raw <= ROOT_MAX)
		else $error("root out of range");

	// a taken transaction reaches out_valid when out_stall stays low throughout
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall
		##1 !out_stall ##1 !out_stall ##1 !out_stall) |=> out_valid)
		else $error("transaction lost in pipe");

endmodule

bind fixed_point_square_root_unit fpsr_checker u_fpsr_checker (.*);
